// ----- design/btpc_pkg.sv -----
package btpc_pkg;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESSURE_SENS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESSURE_OFFSET = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SENS_TEMPCO     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_TEMPCO   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_REF_TEMP        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_SENS       = 3'd5;

    localparam int COEF_W = 16;

    // rated output range
    localparam logic signed [14:0] TEMP_MIN = -15'sd4000;
    localparam logic signed [14:0] TEMP_MAX = 15'sd8500;
    localparam logic [16:0]        PRES_MIN = 17'd1000;
    localparam logic [16:0]        PRES_MAX = 17'd120000;

    typedef struct packed {
        logic [23:0] raw_pressure;
        logic [23:0] raw_temperature;
    } sample_t;

    typedef struct packed {
        logic signed [14:0] temperature_centi_c;
        logic [16:0]        pressure_centi_mbar;
        logic               clamped;
    } result_t;

endpackage

// ----- design/baro_temp_pressure_compensation_unit.sv -----
// Barometer compensation pipeline: turns one raw pressure / raw temperature conversion pair
// into temperature in 0.01 C and pressure in 0.01 mbar using the six factory calibration
// words, with the second-order correction below 20 C (and the extra term below -15 C), and
// saturation to -40.00..85.00 C and 10.00..1200.00 mbar with a clamp flag. It takes one
// sample per cycle while the result is not stalled. The multipliers (dT products, the
// squares of the correction terms, and the pressure product split into two partial
// products) are each followed by a register. A stalled result holds the pipe only as
// far back as there are no bubbles. Calibration words are written through the cfg port,
// which is always ready; write them only while no sample is in flight.
module baro_temp_pressure_compensation_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             sample_valid,
    output logic                             sample_stall,
    input  btpc_pkg::sample_t                sample,
    output logic                             result_valid,
    input  logic                             result_stall,
    output btpc_pkg::result_t                result,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [btpc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [btpc_pkg::COEF_W-1:0]      cfg_data
);
    import btpc_pkg::*;

    localparam int NS = 9;

    localparam logic signed [19:0] TEMP_REF  = 20'sd2000;
    localparam logic signed [19:0] TEMP_COLD = -20'sd1500;

    // calibration words
    logic [COEF_W-1:0] c1_reg, c2_reg, c3_reg, c4_reg, c5_reg, c6_reg;

    // pipeline control
    logic [NS-1:0] valid_reg, valid_next, en;

    // stage 0
    logic [23:0]        s0_d1_reg;
    logic signed [24:0] s0_dt_reg, s0_dt_next;
    // stage 1
    logic [23:0]        s1_d1_reg;
    logic signed [41:0] s1_tc6_reg, s1_tc6_next;
    logic signed [41:0] s1_oc4_reg, s1_oc4_next;
    logic signed [41:0] s1_sc3_reg, s1_sc3_next;
    logic signed [49:0] s1_dtsq_reg, s1_dtsq_next;
    // stage 2
    logic [23:0]        s2_d1_reg;
    logic signed [19:0] s2_temp_reg, s2_temp_next;
    logic signed [41:0] s2_off_reg, s2_off_next;
    logic signed [41:0] s2_sens_reg, s2_sens_next;
    logic [16:0]        s2_t2_reg, s2_t2_next;
    // stage 3
    logic [23:0]        s3_d1_reg;
    logic signed [19:0] s3_temp_reg;
    logic signed [41:0] s3_off_reg;
    logic signed [41:0] s3_sens_reg;
    logic [16:0]        s3_t2_reg;
    logic [35:0]        s3_sq_reg, s3_sq_next;
    logic [35:0]        s3_sq2_reg, s3_sq2_next;
    logic               s3_warm_lo_reg, s3_warm_lo_next;
    logic               s3_cold_reg, s3_cold_next;
    logic signed [19:0] s3_a, s3_b;
    logic signed [39:0] s3_a_sq, s3_b_sq;
    // stage 4
    logic [23:0]        s4_d1_reg;
    logic signed [19:0] s4_temp_reg, s4_temp_next;
    logic signed [41:0] s4_off_reg;
    logic signed [41:0] s4_sens_reg;
    logic [41:0]        s4_off2_reg, s4_off2_next;
    logic [41:0]        s4_sens2_reg, s4_sens2_next;
    logic [41:0]        s4_five_sq, s4_seven_sq2, s4_eleven_sq2;
    logic signed [19:0] s4_t2_ext;
    // stage 5
    logic [23:0]        s5_d1_reg;
    logic signed [19:0] s5_temp_reg;
    logic signed [41:0] s5_off_reg, s5_off_next;
    logic signed [41:0] s5_sens_reg, s5_sens_next;
    // stage 6
    logic signed [19:0] s6_temp_reg;
    logic signed [41:0] s6_off_reg;
    logic [42:0]        s6_pp_lo_reg, s6_pp_lo_next;
    logic signed [47:0] s6_pp_hi_reg, s6_pp_hi_next;
    // stage 7
    logic signed [19:0] s7_temp_reg;
    logic signed [41:0] s7_off_reg;
    logic signed [63:0] s7_prod_reg, s7_prod_next;
    // stage 8 (output)
    result_t            s8_result_reg, s8_result_next;
    logic signed [43:0] s8_q;
    logic signed [28:0] s8_p;

    // ---------------------------------------------------------------- control

    // a stage loads when it is empty or the stage after it moves
    always_comb
    begin
        en[NS-1] = !valid_reg[NS-1] || !result_stall;
        for (int s = NS - 2; s >= 0; s--)
        begin
            en[s] = !valid_reg[s] || en[s + 1];
        end
        valid_next[0] = sample_valid;
        for (int s = 1; s < NS; s++)
        begin
            valid_next[s] = valid_reg[s - 1];
        end
    end

    assign sample_stall = !en[0];
    assign result_valid = valid_reg[NS-1];
    assign result       = s8_result_reg;
    assign cfg_ready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            c1_reg    <= '0;
            c2_reg    <= '0;
            c3_reg    <= '0;
            c4_reg    <= '0;
            c5_reg    <= '0;
            c6_reg    <= '0;
        end
        else
        begin
            for (int s = 0; s < NS; s++)
            begin
                if (en[s])
                begin
                    valid_reg[s] <= valid_next[s];
                end
            end
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_PRESSURE_SENS:   c1_reg <= cfg_data;
                    CFG_PRESSURE_OFFSET: c2_reg <= cfg_data;
                    CFG_SENS_TEMPCO:     c3_reg <= cfg_data;
                    CFG_OFFSET_TEMPCO:   c4_reg <= cfg_data;
                    CFG_REF_TEMP:        c5_reg <= cfg_data;
                    CFG_TEMP_SENS:       c6_reg <= cfg_data;
                    default:             ;
                endcase
            end
        end
    end

    // ---------------------------------------------------------------- datapath

    always_comb
    begin
        // stage 0: dT
        s0_dt_next = $signed({1'b0, sample.raw_temperature}) - $signed({1'b0, c5_reg, 8'd0});

        // stage 1: products with dT
        s1_tc6_next  = s0_dt_reg * $signed({1'b0, c6_reg});
        s1_oc4_next  = s0_dt_reg * $signed({1'b0, c4_reg});
        s1_sc3_next  = s0_dt_reg * $signed({1'b0, c3_reg});
        s1_dtsq_next = s0_dt_reg * s0_dt_reg;

        // stage 2: first-order TEMP, OFF, SENS
        s2_temp_next = $signed({s1_tc6_reg[41], s1_tc6_reg[41:23]}) + TEMP_REF;
        s2_off_next  = $signed({10'd0, c2_reg, 16'd0})
                     + $signed({{7{s1_oc4_reg[41]}}, s1_oc4_reg[41:7]});
        s2_sens_next = $signed({11'd0, c1_reg, 15'd0})
                     + $signed({{8{s1_sc3_reg[41]}}, s1_sc3_reg[41:8]});
        // dT squared is below 2^48
        s2_t2_next   = s1_dtsq_reg[47:31];

        // stage 3: squares of the distance below 20 C and below -15 C
        s3_a            = s2_temp_reg - TEMP_REF;
        s3_b            = s2_temp_reg - TEMP_COLD;
        s3_a_sq         = s3_a * s3_a;
        s3_b_sq         = s3_b * s3_b;
        s3_sq_next      = s3_a_sq[35:0];
        s3_sq2_next     = s3_b_sq[35:0];
        s3_warm_lo_next = s2_temp_reg < TEMP_REF;
        s3_cold_next    = s2_temp_reg < TEMP_COLD;

        // stage 4: second-order terms
        s4_five_sq    = {6'd0, s3_sq_reg} + {4'd0, s3_sq_reg, 2'd0};
        s4_seven_sq2  = {3'd0, s3_sq2_reg, 3'd0} - {6'd0, s3_sq2_reg};
        s4_eleven_sq2 = {3'd0, s3_sq2_reg, 3'd0} + {5'd0, s3_sq2_reg, 1'd0}
                      + {6'd0, s3_sq2_reg};
        s4_t2_ext     = $signed({3'd0, s3_t2_reg});
        if (s3_warm_lo_reg)
        begin
            s4_off2_next  = (s4_five_sq >> 1) + (s3_cold_reg ? s4_seven_sq2 : 42'd0);
            s4_sens2_next = (s4_five_sq >> 2) + (s3_cold_reg ? (s4_eleven_sq2 >> 1) : 42'd0);
            s4_temp_next  = s3_temp_reg - s4_t2_ext;
        end
        else
        begin
            s4_off2_next  = '0;
            s4_sens2_next = '0;
            s4_temp_next  = s3_temp_reg;
        end

        // stage 5: corrected OFF and SENS
        s5_off_next  = s4_off_reg - $signed(s4_off2_reg);
        s5_sens_next = s4_sens_reg - $signed(s4_sens2_reg);

        // stage 6: D1 * SENS as two partial products
        s6_pp_lo_next = s5_d1_reg * s5_sens_reg[18:0];
        s6_pp_hi_next = $signed({1'b0, s5_d1_reg}) * $signed(s5_sens_reg[41:19]);

        // stage 7: recombine, product magnitude stays below 2^61
        s7_prod_next = $signed({s6_pp_hi_reg[44:0], 19'd0}) + $signed({21'd0, s6_pp_lo_reg});

        // stage 8: pressure and saturation
        s8_q = $signed({s7_prod_reg[63], s7_prod_reg[63:21]})
             - $signed({{2{s7_off_reg[41]}}, s7_off_reg});
        s8_p = $signed(s8_q[43:15]);
        s8_result_next.clamped = 1'b0;
        if (s7_temp_reg < 20'(TEMP_MIN))
        begin
            s8_result_next.temperature_centi_c = TEMP_MIN;
            s8_result_next.clamped             = 1'b1;
        end
        else if (s7_temp_reg > 20'(TEMP_MAX))
        begin
            s8_result_next.temperature_centi_c = TEMP_MAX;
            s8_result_next.clamped             = 1'b1;
        end
        else
        begin
            s8_result_next.temperature_centi_c = s7_temp_reg[14:0];
        end
        if (s8_p < $signed({12'd0, PRES_MIN}))
        begin
            s8_result_next.pressure_centi_mbar = PRES_MIN;
            s8_result_next.clamped             = 1'b1;
        end
        else if (s8_p > $signed({12'd0, PRES_MAX}))
        begin
            s8_result_next.pressure_centi_mbar = PRES_MAX;
            s8_result_next.clamped             = 1'b1;
        end
        else
        begin
            s8_result_next.pressure_centi_mbar = s8_p[16:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            s0_d1_reg <= sample.raw_pressure;
            s0_dt_reg <= s0_dt_next;
        end
        if (en[1])
        begin
            s1_d1_reg   <= s0_d1_reg;
            s1_tc6_reg  <= s1_tc6_next;
            s1_oc4_reg  <= s1_oc4_next;
            s1_sc3_reg  <= s1_sc3_next;
            s1_dtsq_reg <= s1_dtsq_next;
        end
        if (en[2])
        begin
            s2_d1_reg   <= s1_d1_reg;
            s2_temp_reg <= s2_temp_next;
            s2_off_reg  <= s2_off_next;
            s2_sens_reg <= s2_sens_next;
            s2_t2_reg   <= s2_t2_next;
        end
        if (en[3])
        begin
            s3_d1_reg      <= s2_d1_reg;
            s3_temp_reg    <= s2_temp_reg;
            s3_off_reg     <= s2_off_reg;
            s3_sens_reg    <= s2_sens_reg;
            s3_t2_reg      <= s2_t2_reg;
            s3_sq_reg      <= s3_sq_next;
            s3_sq2_reg     <= s3_sq2_next;
            s3_warm_lo_reg <= s3_warm_lo_next;
            s3_cold_reg    <= s3_cold_next;
        end
        if (en[4])
        begin
            s4_d1_reg    <= s3_d1_reg;
            s4_temp_reg  <= s4_temp_next;
            s4_off_reg   <= s3_off_reg;
            s4_sens_reg  <= s3_sens_reg;
            s4_off2_reg  <= s4_off2_next;
            s4_sens2_reg <= s4_sens2_next;
        end
        if (en[5])
        begin
            s5_d1_reg   <= s4_d1_reg;
            s5_temp_reg <= s4_temp_reg;
            s5_off_reg  <= s5_off_next;
            s5_sens_reg <= s5_sens_next;
        end
        if (en[6])
        begin
            s6_temp_reg  <= s5_temp_reg;
            s6_off_reg   <= s5_off_reg;
            s6_pp_lo_reg <= s6_pp_lo_next;
            s6_pp_hi_reg <= s6_pp_hi_next;
        end
        if (en[7])
        begin
            s7_temp_reg <= s6_temp_reg;
            s7_off_reg  <= s6_off_reg;
            s7_prod_reg <= s7_prod_next;
        end
        if (en[8])
        begin
            s8_result_reg <= s8_result_next;
        end
    end

endmodule

// ----- design/btpc_checker.sv -----
module btpc_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             sample_valid,
    input logic                             sample_stall,
    input btpc_pkg::sample_t                sample,
    input logic                             result_valid,
    input logic                             result_stall,
    input btpc_pkg::result_t                result
);
    import btpc_pkg::*;

    // nothing comes out in the cycle after a reset cycle
    a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !result_valid)
        else $error("result word valid right after reset");

    // every word lies within the rated range
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |->
            ($signed(result.temperature_centi_c) >= TEMP_MIN) &&
            ($signed(result.temperature_centi_c) <= TEMP_MAX) &&
            (result.pressure_centi_mbar >= PRES_MIN) &&
            (result.pressure_centi_mbar <= PRES_MAX))
        else $error("result word out of rated range");

    // a clamped word sits on at least one range limit
    a_clamp_on_limit: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.clamped |->
            (result.temperature_centi_c == TEMP_MIN) ||
            (result.temperature_centi_c == TEMP_MAX) ||
            (result.pressure_centi_mbar == PRES_MIN) ||
            (result.pressure_centi_mbar == PRES_MAX))
        else $error("clamp flag set with no value at a limit");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("stalled result word changed");

    a_sample_hold: assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid && sample_stall |=> sample_valid && $stable(sample))
        else $error("stalled sample word changed");

endmodule

bind baro_temp_pressure_compensation_unit btpc_checker u_btpc_checker (.*);
